// ===== sv/tls_pkg.sv =====
`default_nettype none
package tls_pkg;

    localparam int CoordW = 16;
    localparam int DistW = 16;
    localparam int QualW = 10;

    // Widths along the solve path.
    localparam int AW = 18;       // 2*(xj - xi)
    localparam int SqW = 32;      // squares of ranges and coordinates
    localparam int CW = 34;       // right-hand sides c1, c2
    localparam int PW = 36;       // a*b products
    localparam int DW = 37;       // determinant
    localparam int MW = 52;       // c*b products
    localparam int NW = 54;       // Cramer numerators
    localparam int DivNW = NW + 2;
    localparam int DivDW = DW + 1;
    localparam int QBits = 17;    // quotient bits below the overflow test
    localparam int DivSteps = QBits + 1;

    localparam int DiffW = 17;    // position minus anchor
    localparam int RadW = 33;     // dx^2 + dy^2
    localparam int RootW = 17;
    localparam int TrialW = 36;
    localparam int ErrW = 17;
    localparam int SumW = 19;

    localparam int FrontLat = 5;
    localparam int DivLat = DivSteps + 2;
    localparam int SqrtLat = RootW;
    localparam int TotalLat = FrontLat + DivLat + 2 + SqrtLat + 2;

    localparam int PosMax = 32767;
    localparam int NegMax = 32768;
    localparam int QualMax = 1000;
    localparam int MeanSatT = 3003;   // S+1 at or above this gives mean above 1000
    localparam int Recip3 = 2731;
    localparam int Recip3Shift = 13;
    localparam int MeanTW = 12;

    typedef enum logic [2:0] {
        REG_A1X = 3'd0,
        REG_A1Y = 3'd1,
        REG_A2X = 3'd2,
        REG_A2Y = 3'd3,
        REG_A3X = 3'd4,
        REG_A3Y = 3'd5
    } tls_reg_t;

    typedef struct packed {
        logic [DistW-1:0] dist_1;
        logic [DistW-1:0] dist_2;
        logic [DistW-1:0] dist_3;
    } tls_in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic                     solved;
        logic [QualW-1:0]         quality;
    } tls_out_t;

    typedef struct packed {
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [CoordW-1:0] x2;
        logic signed [CoordW-1:0] y2;
        logic signed [CoordW-1:0] x3;
        logic signed [CoordW-1:0] y3;
    } tls_anchor_t;

    typedef struct packed {
        logic                 vld;
        logic signed [NW-1:0] num_x;
        logic signed [NW-1:0] num_y;
        logic signed [DW-1:0] det;
        tls_anchor_t          anc;
        tls_in_t              rng;
    } tls_sys_t;

    typedef struct packed {
        logic               neg;
        logic               ovf;
        logic [DivNW-1:0]   rem;
        logic [DivDW-1:0]   den;
        logic [QBits-1:0]   quo;
    } tls_dstep_t;

    typedef struct packed {
        logic [RadW-1:0]    rem;
        logic [RootW-1:0]   root;
    } tls_rstep_t;

endpackage
`default_nettype wire

// ===== sv/tls_front.sv =====
`default_nettype none
module tls_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  tls_pkg::tls_in_t     item,
    input  tls_pkg::tls_anchor_t anc,
    output tls_pkg::tls_sys_t    sys
);
    import tls_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    tls_in_t     d1_reg, d2_reg, d3_reg, d4_reg, d5_reg;
    tls_anchor_t an1_reg, an2_reg, an3_reg, an4_reg, an5_reg;

    logic signed [DiffW-1:0] ha1, hb1, ha2, hb2;
    logic signed [AW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [AW-1:0] a1_3_reg, b1_3_reg, a2_3_reg, b2_3_reg;
    logic [SqW-1:0] ds1_reg, ds2_reg, ds3_reg;
    logic signed [SqW-1:0] xs1_reg, ys1_reg, xs2_reg, ys2_reg, xs3_reg, ys3_reg;

    logic signed [CW-1:0] base, c1_next, c2_next, c1_reg, c2_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [DW-1:0] det4_reg, det5_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;

    assign ha1 = DiffW'(an1_reg.x2) - DiffW'(an1_reg.x1);
    assign hb1 = DiffW'(an1_reg.y2) - DiffW'(an1_reg.y1);
    assign ha2 = DiffW'(an1_reg.x3) - DiffW'(an1_reg.x1);
    assign hb2 = DiffW'(an1_reg.y3) - DiffW'(an1_reg.y1);

    assign base = $signed({2'b00, ds1_reg}) - CW'(xs1_reg) - CW'(ys1_reg);
    assign c1_next = base - $signed({2'b00, ds2_reg}) + CW'(xs2_reg) + CW'(ys2_reg);
    assign c2_next = base - $signed({2'b00, ds3_reg}) + CW'(xs3_reg) + CW'(ys3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg  <= item;
        an1_reg <= anc;

        d2_reg  <= d1_reg;
        an2_reg <= an1_reg;
        a1_reg  <= {ha1, 1'b0};
        b1_reg  <= {hb1, 1'b0};
        a2_reg  <= {ha2, 1'b0};
        b2_reg  <= {hb2, 1'b0};
        ds1_reg <= d1_reg.dist_1 * d1_reg.dist_1;
        ds2_reg <= d1_reg.dist_2 * d1_reg.dist_2;
        ds3_reg <= d1_reg.dist_3 * d1_reg.dist_3;
        xs1_reg <= an1_reg.x1 * an1_reg.x1;
        ys1_reg <= an1_reg.y1 * an1_reg.y1;
        xs2_reg <= an1_reg.x2 * an1_reg.x2;
        ys2_reg <= an1_reg.y2 * an1_reg.y2;
        xs3_reg <= an1_reg.x3 * an1_reg.x3;
        ys3_reg <= an1_reg.y3 * an1_reg.y3;

        d3_reg   <= d2_reg;
        an3_reg  <= an2_reg;
        a1_3_reg <= a1_reg;
        b1_3_reg <= b1_reg;
        a2_3_reg <= a2_reg;
        b2_3_reg <= b2_reg;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
        p1_reg   <= a1_reg * b2_reg;
        p2_reg   <= a2_reg * b1_reg;

        d4_reg   <= d3_reg;
        an4_reg  <= an3_reg;
        det4_reg <= DW'(p1_reg) - DW'(p2_reg);
        m1_reg   <= c1_reg * b2_3_reg;
        m2_reg   <= c2_reg * b1_3_reg;
        m3_reg   <= a1_3_reg * c2_reg;
        m4_reg   <= a2_3_reg * c1_reg;

        d5_reg   <= d4_reg;
        an5_reg  <= an4_reg;
        det5_reg <= det4_reg;
        nx_reg   <= NW'(m1_reg) - NW'(m2_reg);
        ny_reg   <= NW'(m3_reg) - NW'(m4_reg);
    end

    always_comb
    begin
        sys.vld   = v5_reg;
        sys.num_x = nx_reg;
        sys.num_y = ny_reg;
        sys.det   = det5_reg;
        sys.anc   = an5_reg;
        sys.rng   = d5_reg;
    end

endmodule
`default_nettype wire

// ===== sv/tls_div.sv =====
`default_nettype none
module tls_div (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_vld,
    input  logic signed [tls_pkg::NW-1:0]             num,
    input  logic signed [tls_pkg::DW-1:0]             den,
    output logic                                      out_vld,
    output logic signed [tls_pkg::CoordW-1:0]         quo
);
    import tls_pkg::*;

    logic [DivSteps:0] vld_reg;
    tls_dstep_t        st_reg [0:DivSteps];
    tls_dstep_t        st_next [1:DivSteps];
    logic              ov_vld_reg;
    logic signed [CoordW-1:0] quo_reg;

    logic [NW-1:0] un;
    logic [DW-1:0] ud;
    tls_dstep_t    prep;
    tls_dstep_t    last;
    logic [QBits-1:0] mag;

    assign un = num[NW-1] ? NW'(-num) : NW'(num);
    assign ud = den[DW-1] ? DW'(-den) : DW'(den);

    always_comb
    begin
        prep.neg = num[NW-1] ^ den[DW-1];
        prep.ovf = 1'b0;
        prep.rem = {un, 1'b0} + DivNW'(ud);
        prep.den = {ud, 1'b0};
        prep.quo = '0;
    end

    // Stage 1 only tests for a quotient too large for 17 bits; the rest are restoring steps.
    for (genvar j = 1; j <= DivSteps; j++)
    begin : g_step
        localparam int Sh = DivSteps - j;
        logic [DivNW-1:0] sub;
        assign sub = DivNW'(st_reg[j-1].den) << Sh;
        always_comb
        begin
            st_next[j] = st_reg[j-1];
            if (j == 1)
            begin
                st_next[j].ovf = (st_reg[j-1].rem >= sub);
            end
            else if (st_reg[j-1].rem >= sub)
            begin
                st_next[j].rem = st_reg[j-1].rem - sub;
                st_next[j].quo[Sh] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            ov_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= {vld_reg[DivSteps-1:0], in_vld};
            ov_vld_reg <= vld_reg[DivSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= prep;
        for (int k = 1; k <= DivSteps; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        quo_reg <= last.neg ? CoordW'(-mag) : CoordW'(mag);
    end

    always_comb
    begin
        last = st_reg[DivSteps];
        if (last.neg)
        begin
            mag = (last.ovf || last.quo > QBits'(NegMax)) ? QBits'(NegMax) : last.quo;
        end
        else
        begin
            mag = (last.ovf || last.quo > QBits'(PosMax)) ? QBits'(PosMax) : last.quo;
        end
    end

    assign out_vld = ov_vld_reg;
    assign quo = quo_reg;

endmodule
`default_nettype wire

// ===== sv/tls_isqrt.sv =====
`default_nettype none
module tls_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  logic [tls_pkg::RadW-1:0]     val,
    output logic                         out_vld,
    output logic [tls_pkg::RootW-1:0]    root
);
    import tls_pkg::*;

    logic [RootW-1:0] vld_reg;
    tls_rstep_t       st_reg [1:RootW];
    tls_rstep_t       st_in  [0:RootW-1];
    tls_rstep_t       st_next [1:RootW];

    assign st_in[0] = '{rem: val, root: '0};
    for (genvar k = 1; k < RootW; k++)
    begin : g_link
        assign st_in[k] = st_reg[k];
    end

    // rem holds val - root^2; each step tries to set one more root bit.
    for (genvar k = 1; k <= RootW; k++)
    begin : g_step
        localparam int Bit = RootW - k;
        logic [TrialW-1:0] trial;
        assign trial = (TrialW'(st_in[k-1].root) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
        always_comb
        begin
            st_next[k] = st_in[k-1];
            if (TrialW'(st_in[k-1].rem) >= trial)
            begin
                st_next[k].rem = st_in[k-1].rem - RadW'(trial);
                st_next[k].root[Bit] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[RootW-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= RootW; k++)
        begin
            st_reg[k] <= st_next[k];
        end
    end

    assign out_vld = vld_reg[RootW-1];
    assign root = st_reg[RootW].root;

endmodule
`default_nettype wire

// ===== sv/trilateration_2d_solver_top.sv =====
`default_nettype none
// Two-dimensional position from three measured ranges to three fixed anchors.
// Configuration: write the six anchor coordinates (x1, y1, x2, y2, x3, y3 at
// indexes 0 to 5) through cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high and writes to other indexes are dropped. Write only while no item is
// in flight.
// Input: an item is taken at each clock edge with start high and busy low.
// busy stays low, so a new range triple can be issued every cycle.
// Output: each item gives one result on the result port, marked by done for
// exactly one cycle. The receiver cannot
// hold results off, and none is needed: the pipeline never stalls.
// Throughput is one item per cycle; the Cramer quotients come from the 18-step
// pipelined divider, and the range check uses the 17-step pipelined square
// root.
// Reset clears the anchors to zero and drops every item in flight.
module trilateration_2d_solver_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tls_pkg::tls_in_t              item,
    output logic                          done,
    output tls_pkg::tls_out_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [tls_pkg::CoordW-1:0]    cfg_data
);
    import tls_pkg::*;

    tls_anchor_t anc_reg;
    tls_sys_t    sys;
    logic        take;

    logic vx, vy;
    logic signed [CoordW-1:0] qx, qy;

    tls_anchor_t sa_reg [0:DivLat-1];
    tls_in_t     sd_reg [0:DivLat-1];
    logic        sz_reg [0:DivLat-1];

    logic t1_vld_reg, t2_vld_reg, t3_vld_reg, out_vld_reg;
    logic signed [DiffW-1:0] dx_reg [0:2];
    logic signed [DiffW-1:0] dy_reg [0:2];
    logic [RadW-1:0] rad_reg [0:2];
    logic signed [CoordW-1:0] px1_reg, py1_reg, px2_reg, py2_reg;
    tls_in_t dist1_reg, dist2_reg;
    logic sol1_reg, sol2_reg;

    logic signed [CoordW-1:0] qpx_reg [0:SqrtLat-1];
    logic signed [CoordW-1:0] qpy_reg [0:SqrtLat-1];
    tls_in_t                  qd_reg  [0:SqrtLat-1];
    logic                     qs_reg  [0:SqrtLat-1];

    logic [2:0] rv;
    logic [RootW-1:0] ex [0:2];
    logic [DistW-1:0] dm [0:2];
    logic [ErrW-1:0]  err [0:2];
    logic [SumW-1:0]  sum_next, sum_reg;
    logic signed [CoordW-1:0] px3_reg, py3_reg;
    logic sol3_reg;

    logic [SumW-1:0]   tval;
    logic [2*MeanTW-1:0] prod;
    logic [QualW-1:0]  mean;
    tls_out_t          res_next, res_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anc_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tls_reg_t'(cfg_index))
                REG_A1X: anc_reg.x1 <= cfg_data;
                REG_A1Y: anc_reg.y1 <= cfg_data;
                REG_A2X: anc_reg.x2 <= cfg_data;
                REG_A2Y: anc_reg.y2 <= cfg_data;
                REG_A3X: anc_reg.x3 <= cfg_data;
                REG_A3Y: anc_reg.y3 <= cfg_data;
                default: ;
            endcase
        end
    end

    tls_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .anc   (anc_reg),
        .sys   (sys)
    );

    tls_div u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (sys.vld),
        .num     (sys.num_x),
        .den     (sys.det),
        .out_vld (vx),
        .quo     (qx)
    );

    tls_div u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (sys.vld),
        .num     (sys.num_y),
        .den     (sys.det),
        .out_vld (vy),
        .quo     (qy)
    );

    // Side data rides alongside the dividers.
    always_ff @(posedge clk)
    begin
        sa_reg[0] <= sys.anc;
        sd_reg[0] <= sys.rng;
        sz_reg[0] <= (sys.det == '0);
        for (int k = 1; k < DivLat; k++)
        begin
            sa_reg[k] <= sa_reg[k-1];
            sd_reg[k] <= sd_reg[k-1];
            sz_reg[k] <= sz_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        px1_reg   <= qx;
        py1_reg   <= qy;
        dist1_reg <= sd_reg[DivLat-1];
        sol1_reg  <= !sz_reg[DivLat-1];
        dx_reg[0] <= DiffW'(qx) - DiffW'(sa_reg[DivLat-1].x1);
        dy_reg[0] <= DiffW'(qy) - DiffW'(sa_reg[DivLat-1].y1);
        dx_reg[1] <= DiffW'(qx) - DiffW'(sa_reg[DivLat-1].x2);
        dy_reg[1] <= DiffW'(qy) - DiffW'(sa_reg[DivLat-1].y2);
        dx_reg[2] <= DiffW'(qx) - DiffW'(sa_reg[DivLat-1].x3);
        dy_reg[2] <= DiffW'(qy) - DiffW'(sa_reg[DivLat-1].y3);

        px2_reg   <= px1_reg;
        py2_reg   <= py1_reg;
        dist2_reg <= dist1_reg;
        sol2_reg  <= sol1_reg;
        for (int k = 0; k < 3; k++)
        begin
            rad_reg[k] <= RadW'(dx_reg[k] * dx_reg[k]) + RadW'(dy_reg[k] * dy_reg[k]);
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_root
        tls_isqrt u_isqrt (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (t2_vld_reg),
            .val     (rad_reg[k]),
            .out_vld (rv[k]),
            .root    (ex[k])
        );
    end

    always_ff @(posedge clk)
    begin
        qpx_reg[0] <= px2_reg;
        qpy_reg[0] <= py2_reg;
        qd_reg[0]  <= dist2_reg;
        qs_reg[0]  <= sol2_reg;
        for (int k = 1; k < SqrtLat; k++)
        begin
            qpx_reg[k] <= qpx_reg[k-1];
            qpy_reg[k] <= qpy_reg[k-1];
            qd_reg[k]  <= qd_reg[k-1];
            qs_reg[k]  <= qs_reg[k-1];
        end
    end

    assign dm[0] = qd_reg[SqrtLat-1].dist_1;
    assign dm[1] = qd_reg[SqrtLat-1].dist_2;
    assign dm[2] = qd_reg[SqrtLat-1].dist_3;

    for (genvar k = 0; k < 3; k++)
    begin : g_err
        assign err[k] = (ex[k] >= RootW'(dm[k])) ? ErrW'(ex[k] - RootW'(dm[k]))
                                                : ErrW'(RootW'(dm[k]) - ex[k]);
    end

    assign sum_next = SumW'(err[0]) + SumW'(err[1]) + SumW'(err[2]);

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        px3_reg  <= qpx_reg[SqrtLat-1];
        py3_reg  <= qpy_reg[SqrtLat-1];
        sol3_reg <= qs_reg[SqrtLat-1];
        res_reg  <= res_next;
    end

    // Mean error is (S+1)/3; below the clamp point a reciprocal multiply is exact.
    always_comb
    begin
        tval = sum_reg + SumW'(1);
        prod = MeanTW'(tval) * MeanTW'(Recip3);
        if (tval >= SumW'(MeanSatT))
        begin
            mean = QualW'(QualMax);
        end
        else
        begin
            mean = QualW'(prod >> Recip3Shift);
        end
        if (sol3_reg)
        begin
            res_next.pos_x   = px3_reg;
            res_next.pos_y   = py3_reg;
            res_next.solved  = 1'b1;
            res_next.quality = QualW'(QualMax) - mean;
        end
        else
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg  <= 1'b0;
            t2_vld_reg  <= 1'b0;
            t3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            t1_vld_reg  <= vx;
            t2_vld_reg  <= t1_vld_reg;
            t3_vld_reg  <= rv[0];
            out_vld_reg <= t3_vld_reg;
        end
    end

    assign done = out_vld_reg;
    assign result = res_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##TotalLat done)
        else $error("result missing at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, TotalLat))
        else $error("result without a matching item");

    a_lanes_align: assert property (@(posedge clk) disable iff (!rst_n)
        vx == vy && (rv == 3'b000 || rv == 3'b111))
        else $error("parallel lanes out of step");

    a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.solved |-> result.pos_x == '0 && result.pos_y == '0
                                   && result.quality == '0)
        else $error("unsolved result not zero");

    a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.quality <= QualW'(QualMax))
        else $error("quality above full scale");

endmodule
`default_nettype wire
